// ----- hdl/spi_pss_pkg.sv -----
// ----------------------------------------------------------------------------
// spi_pss_pkg
// Shared types, constants and helpers for the serial clock prescaler search.
// ----------------------------------------------------------------------------
package spi_pss_pkg;

  // Field widths.
  localparam int FIELD_W  = 28;
  localparam int PRI_W    = 2;
  localparam int SEC_W    = 3;
  localparam int IDX_W    = PRI_W + SEC_W;
  localparam int NUM_PRI  = 1 << PRI_W;
  localparam int NUM_SEC  = 1 << SEC_W;
  localparam int NUM_CAND = NUM_PRI * NUM_SEC;
  localparam int SHIFT_W  = 4;

  // Latency from an accepted word to its result strobe.
  localparam int PIPE_DEPTH = 5;

  // The 1:1 with 1:1 pair is never a candidate.
  localparam logic [PRI_W-1:0] SKIP_PRIMARY   = 2'd3;
  localparam logic [SEC_W-1:0] SKIP_SECONDARY = 3'd7;

  localparam logic [FIELD_W-1:0] CORE_CLOCK_RESET = 28'd16000000;

  typedef logic [FIELD_W-1:0] word_t;

  // Every candidate divisor is a power of two times one of these odd factors.
  typedef enum logic [1:0] {ODD_1, ODD_3, ODD_5, ODD_7} odd_sel_t;

  localparam int NUM_ODD = 3;

  // Odd divisors 3, 5 and 7 with their truncated reciprocals (2^32 / d).
  localparam logic [2:0]  ODD_DIV   [NUM_ODD] = '{3'd3, 3'd5, 3'd7};
  localparam logic [31:0] ODD_RECIP [NUM_ODD] = '{32'd1431655765, 32'd858993459,
                                                  32'd613566756};
  localparam int RECIP_W = 32;

  // Primary ratios 64, 16, 4, 1 as shift amounts.
  localparam logic [SHIFT_W-1:0] PRI_SHIFT [NUM_PRI] = '{4'd6, 4'd4, 4'd2, 4'd0};

  // Secondary ratio 8 - code, split into odd factor and shift.
  localparam logic [SHIFT_W-1:0] SEC_SHIFT [NUM_SEC] = '{4'd3, 4'd0, 4'd1, 4'd0,
                                                        4'd2, 4'd0, 4'd1, 4'd0};
  localparam odd_sel_t SEC_ODD [NUM_SEC] = '{ODD_1, ODD_7, ODD_3, ODD_5,
                                            ODD_1, ODD_3, ODD_1, ODD_1};

  // Quotients of the clock by 3, 5 and 7 with the word they belong to.
  typedef struct packed {
    logic                      valid;
    word_t                     wanted;
    word_t                     clock;
    logic [NUM_ODD-1:0][FIELD_W-1:0] quot;
  } quot_t;

  // One candidate: its error and its code pair (primary in the high bits).
  typedef struct packed {
    word_t            err;
    logic [IDX_W-1:0] idx;
  } cand_t;

  // The left candidate comes first in search order and wins ties.
  function automatic cand_t pick_better(cand_t a, cand_t b);
    return (b.err < a.err) ? b : a;
  endfunction

endpackage

// ----- hdl/spi_pss_div.sv -----
// ----------------------------------------------------------------------------
// spi_pss_div
// Divides the core clock by 3, 5 and 7 with reciprocal multiplies and a
// one-step correction, over two register stages.
// ----------------------------------------------------------------------------
module spi_pss_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  valid_in,
  input  spi_pss_pkg::word_t    wanted_in,
  input  spi_pss_pkg::word_t    clock_in,
  output spi_pss_pkg::quot_t    quot_out
);

  localparam int PROD_W = spi_pss_pkg::FIELD_W + spi_pss_pkg::RECIP_W;
  localparam int REM_W  = spi_pss_pkg::FIELD_W + 3;

  logic [PROD_W-1:0]               prod   [spi_pss_pkg::NUM_ODD];
  logic                            valid_a;
  spi_pss_pkg::word_t              wanted_a;
  spi_pss_pkg::word_t              clock_a;
  spi_pss_pkg::word_t              est_a  [spi_pss_pkg::NUM_ODD];
  logic [REM_W-1:0]                back   [spi_pss_pkg::NUM_ODD];
  logic [REM_W-1:0]                rem    [spi_pss_pkg::NUM_ODD];
  spi_pss_pkg::word_t              fixed  [spi_pss_pkg::NUM_ODD];
  spi_pss_pkg::quot_t              stage_b;

  // Reciprocal products; the estimate is at most one below the true quotient.
  always_comb begin
    for (int i = 0; i < spi_pss_pkg::NUM_ODD; i++) begin
      prod[i] = PROD_W'(clock_in) * PROD_W'(spi_pss_pkg::ODD_RECIP[i]);
    end
  end

  // Stage A valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else begin
      valid_a <= valid_in;
    end
  end

  // Stage A payload.
  always_ff @(posedge clk) begin
    wanted_a <= wanted_in;
    clock_a  <= clock_in;
    for (int i = 0; i < spi_pss_pkg::NUM_ODD; i++) begin
      est_a[i] <= prod[i][PROD_W-1:spi_pss_pkg::RECIP_W];
    end
  end

  // Correction: bump the estimate when the remainder reaches the divisor.
  always_comb begin
    for (int i = 0; i < spi_pss_pkg::NUM_ODD; i++) begin
      back[i]  = REM_W'(est_a[i]) * REM_W'(spi_pss_pkg::ODD_DIV[i]);
      rem[i]   = REM_W'(clock_a) - back[i];
      fixed[i] = est_a[i] +
                 spi_pss_pkg::FIELD_W'(rem[i] >= REM_W'(spi_pss_pkg::ODD_DIV[i]));
    end
  end

  // Stage B valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_b.valid <= 1'b0;
    end else begin
      stage_b.valid <= valid_a;
    end
  end

  // Stage B payload.
  always_ff @(posedge clk) begin
    stage_b.wanted <= wanted_a;
    stage_b.clock  <= clock_a;
    for (int i = 0; i < spi_pss_pkg::NUM_ODD; i++) begin
      stage_b.quot[i] <= fixed[i];
    end
  end

  assign quot_out = stage_b;

endmodule

// ----- hdl/spi_pss_err.sv -----
// ----------------------------------------------------------------------------
// spi_pss_err
// Forms all candidate rates from the quotients by shifting and registers the
// absolute error of each against the requested rate.
// ----------------------------------------------------------------------------
module spi_pss_err (
  input  logic                                           clk,
  input  logic                                           rst,
  input  spi_pss_pkg::quot_t                             quot_in,
  output logic                                           valid_out,
  output spi_pss_pkg::cand_t [spi_pss_pkg::NUM_CAND-1:0] cands_out
);

  spi_pss_pkg::cand_t [spi_pss_pkg::NUM_CAND-1:0] cands;

  // One error unit per code pair.
  for (genvar g = 0; g < spi_pss_pkg::NUM_CAND; g++) begin : g_cand
    localparam int PI = g / spi_pss_pkg::NUM_SEC;
    localparam int SI = g % spi_pss_pkg::NUM_SEC;
    localparam logic SKIP = (PI == int'(spi_pss_pkg::SKIP_PRIMARY)) &&
                            (SI == int'(spi_pss_pkg::SKIP_SECONDARY));

    spi_pss_pkg::word_t base;
    spi_pss_pkg::word_t rate;
    spi_pss_pkg::word_t err;

    // Pick the odd-factor quotient, then apply the power-of-two part.
    always_comb begin
      case (spi_pss_pkg::SEC_ODD[SI])
        spi_pss_pkg::ODD_3: base = quot_in.quot[0];
        spi_pss_pkg::ODD_5: base = quot_in.quot[1];
        spi_pss_pkg::ODD_7: base = quot_in.quot[2];
        default:            base = quot_in.clock;
      endcase
      rate = base >> (spi_pss_pkg::PRI_SHIFT[PI] + spi_pss_pkg::SEC_SHIFT[SI]);
      if (SKIP) begin
        // The skipped pair sits last and carries the largest error, so it loses.
        err = '1;
      end else if (rate > quot_in.wanted) begin
        err = rate - quot_in.wanted;
      end else begin
        err = quot_in.wanted - rate;
      end
    end

    always_ff @(posedge clk) begin
      cands[g].err <= err;
      cands[g].idx <= spi_pss_pkg::IDX_W'(g);
    end
  end

  // Stage C valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= quot_in.valid;
    end
  end

  assign cands_out = cands;

endmodule

// ----- hdl/spi_pss_tree.sv -----
// ----------------------------------------------------------------------------
// spi_pss_tree
// Registered minimum tree over all candidates: two levels in the first
// stage, three in the second. The earlier candidate wins ties.
// ----------------------------------------------------------------------------
module spi_pss_tree (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           valid_in,
  input  spi_pss_pkg::cand_t [spi_pss_pkg::NUM_CAND-1:0] cands_in,
  output logic                                           valid_out,
  output logic [spi_pss_pkg::IDX_W-1:0]                  best_idx
);

  localparam int N1 = spi_pss_pkg::NUM_CAND / 2;
  localparam int N2 = spi_pss_pkg::NUM_CAND / 4;
  localparam int N3 = spi_pss_pkg::NUM_CAND / 8;
  localparam int N4 = spi_pss_pkg::NUM_CAND / 16;

  spi_pss_pkg::cand_t [N1-1:0] lvl1;
  spi_pss_pkg::cand_t [N2-1:0] lvl2;
  spi_pss_pkg::cand_t [N2-1:0] mid;
  logic                        valid_d;
  spi_pss_pkg::cand_t [N3-1:0] lvl3;
  spi_pss_pkg::cand_t [N4-1:0] lvl4;
  spi_pss_pkg::cand_t          lvl5;

  // First two levels.
  always_comb begin
    for (int i = 0; i < N1; i++) begin
      lvl1[i] = spi_pss_pkg::pick_better(cands_in[2*i], cands_in[2*i+1]);
    end
    for (int i = 0; i < N2; i++) begin
      lvl2[i] = spi_pss_pkg::pick_better(lvl1[2*i], lvl1[2*i+1]);
    end
  end

  // Stage D.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_d <= 1'b0;
    end else begin
      valid_d <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    mid <= lvl2;
  end

  // Last three levels.
  always_comb begin
    for (int i = 0; i < N3; i++) begin
      lvl3[i] = spi_pss_pkg::pick_better(mid[2*i], mid[2*i+1]);
    end
    for (int i = 0; i < N4; i++) begin
      lvl4[i] = spi_pss_pkg::pick_better(lvl3[2*i], lvl3[2*i+1]);
    end
    lvl5 = spi_pss_pkg::pick_better(lvl4[0], lvl4[1]);
  end

  // Stage E: the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_d;
    end
  end

  always_ff @(posedge clk) begin
    best_idx <= lvl5.idx;
  end

endmodule

// ----- hdl/spi_prescaler_search_unit.sv -----
// ----------------------------------------------------------------------------
// spi_prescaler_search_unit
// Picks the primary and secondary prescaler codes whose serial clock rate
// comes closest to a requested rate.
// ----------------------------------------------------------------------------
// A new request word is taken on every clock cycle in which start is high;
// busy stays low, so the unit never refuses a word. Each word yields exactly
// one result, shown on primary_code and secondary_code for one cycle with
// done high. The receiver cannot hold results off. The latency is set by
// the five register stages: a reciprocal multiply and its correction that
// divide the core clock by 3, 5 and 7, the error stage that compares all
// candidate rates at once, and a two-stage minimum tree. The core clock
// register is sampled when a word is taken, so a write never affects words
// already in flight.
// ----------------------------------------------------------------------------
module spi_prescaler_search_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [spi_pss_pkg::FIELD_W-1:0] wanted_rate_hz,
  output logic                            done,
  output logic [spi_pss_pkg::PRI_W-1:0]   primary_code,
  output logic [spi_pss_pkg::SEC_W-1:0]   secondary_code,
  input  logic                            core_clock_hz_we,
  input  logic [spi_pss_pkg::FIELD_W-1:0] core_clock_hz
);

  spi_pss_pkg::word_t                             core_clock;
  logic                                           accept;
  spi_pss_pkg::quot_t                             quot;
  logic                                           valid_c;
  spi_pss_pkg::cand_t [spi_pss_pkg::NUM_CAND-1:0] cands;
  logic [spi_pss_pkg::IDX_W-1:0]                  best_idx;

  // Core clock configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      core_clock <= spi_pss_pkg::CORE_CLOCK_RESET;
    end else if (core_clock_hz_we) begin
      core_clock <= core_clock_hz;
    end
  end

  // The pipeline never stalls.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Division by the odd factors.
  spi_pss_div u_div (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (accept),
    .wanted_in (wanted_rate_hz),
    .clock_in  (core_clock),
    .quot_out  (quot)
  );

  // Candidate errors.
  spi_pss_err u_err (
    .clk       (clk),
    .rst       (rst),
    .quot_in   (quot),
    .valid_out (valid_c),
    .cands_out (cands)
  );

  // Minimum search.
  spi_pss_tree u_tree (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (valid_c),
    .cands_in  (cands),
    .valid_out (done),
    .best_idx  (best_idx)
  );

  // The code pair is packed primary-major in the candidate index.
  assign primary_code   = best_idx[spi_pss_pkg::IDX_W-1:spi_pss_pkg::SEC_W];
  assign secondary_code = best_idx[spi_pss_pkg::SEC_W-1:0];

`ifndef SYNTH
  // Every taken word produces its result after the fixed latency.
  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(spi_pss_pkg::PIPE_DEPTH) done)
    else $error("request word did not produce a result on time");

  // No result appears without a word taken the fixed latency earlier.
  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, spi_pss_pkg::PIPE_DEPTH))
    else $error("result strobe without a matching request word");

  // The skipped pair is never chosen.
  a_no_skip_pair: assert property (@(posedge clk) disable iff (rst)
    done |-> !(primary_code == spi_pss_pkg::SKIP_PRIMARY &&
               secondary_code == spi_pss_pkg::SKIP_SECONDARY))
    else $error("skipped prescaler pair chosen");

  // With a zero core clock every rate is zero and the first pair wins.
  a_zero_clock: assert property (@(posedge clk) disable iff (rst)
    (accept && core_clock == '0) |-> ##(spi_pss_pkg::PIPE_DEPTH)
      (primary_code == '0 && secondary_code == '0))
    else $error("zero core clock did not select the first pair");
`endif

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the serial clock prescaler search unit. Request
// words go in through the start/busy handshake with random gaps, and each
// word's expected code pair is computed when the word is taken. Every result
// strobe is compared with the oldest pending expectation. The run covers
// several core clock settings, the extremes among them, ties between
// candidates, and requests out of the stated range.
// ----------------------------------------------------------------------------
module testbench;
  import spi_pss_pkg::*;

  // Division ratios of the primary prescaler codes 0..3.
  localparam int unsigned PRIMARY_RATIO [NUM_PRI] = '{64, 16, 4, 1};
  localparam word_t       FIELD_MAX = {FIELD_W{1'b1}};
  localparam word_t       RATE_TOP  = 28'd200000000;

  // Expected code pair for one request, with the inputs that produced it.
  typedef struct packed {
    logic [PRI_W-1:0] primary;
    logic [SEC_W-1:0] secondary;
    word_t            wanted;
    word_t            clock_hz;
  } prescale_pick_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  logic  busy;
  word_t wanted_rate_hz = '0;
  logic  done;
  logic [PRI_W-1:0] primary_code;
  logic [SEC_W-1:0] secondary_code;
  logic  core_clock_hz_we = 1'b0;
  word_t core_clock_hz = '0;

  prescale_pick_t pick_queue[$];
  word_t model_core_clock = CORE_CLOCK_RESET;
  word_t cur_core_clock = CORE_CLOCK_RESET;
  bit    no_gaps = 1'b0;
  int    fail_count = 0;
  int    accepted_count = 0;
  int    setting_count = 0;

  spi_prescaler_search_unit dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .wanted_rate_hz   (wanted_rate_hz),
    .done             (done),
    .primary_code     (primary_code),
    .secondary_code   (secondary_code),
    .core_clock_hz_we (core_clock_hz_we),
    .core_clock_hz    (core_clock_hz)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hang guard: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  // Search every allowed code pair; the first smallest error wins.
  function automatic prescale_pick_t best_prescaler(word_t clock_hz, word_t wanted_hz);
    prescale_pick_t pick;
    logic [31:0]    best_err;
    logic [31:0]    divisor;
    logic [31:0]    rate;
    logic [31:0]    err;
    best_err = 32'hFFFF_FFFF;
    pick.primary = '0;
    pick.secondary = '0;
    pick.wanted = wanted_hz;
    pick.clock_hz = clock_hz;
    for (int p = 0; p < NUM_PRI; p++) begin
      for (int s = 0; s < NUM_SEC; s++) begin
        if (p == SKIP_PRIMARY && s == SKIP_SECONDARY) continue;
        divisor = PRIMARY_RATIO[p] * (NUM_SEC - s);
        rate = {4'b0, clock_hz} / divisor;
        err = (rate > {4'b0, wanted_hz}) ? rate - {4'b0, wanted_hz}
                                         : {4'b0, wanted_hz} - rate;
        if (err < best_err) begin
          best_err = err;
          pick.primary = PRI_W'(p);
          pick.secondary = SEC_W'(s);
        end
      end
    end
    return pick;
  endfunction

  // Candidate rate of one code pair at the current core clock.
  function automatic longint candidate_rate(int p, int s);
    return longint'(cur_core_clock) / (PRIMARY_RATIO[p] * (NUM_SEC - s));
  endfunction

  // Random request: near a candidate, halfway between two, small, or any value.
  function automatic word_t rand_wanted();
    longint value;
    case ($urandom_range(0, 3))
      0: value = candidate_rate($urandom_range(0, 3), $urandom_range(0, 7))
                 + $urandom_range(0, 40) - 20;
      1: value = (candidate_rate($urandom_range(0, 3), $urandom_range(0, 7))
                 + candidate_rate($urandom_range(0, 3), $urandom_range(0, 7))
                 + $urandom_range(0, 1)) / 2;
      2: value = $urandom_range(0, 2000);
      default: value = $urandom_range(0, 32'hFFFF_FFFF) & FIELD_MAX;
    endcase
    if (value < 0) value = 0;
    if (value > FIELD_MAX) value = FIELD_MAX;
    return word_t'(value);
  endfunction

  // Gap before a word: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Send one request word and return at the edge that takes it.
  task automatic send_rate(input word_t rate);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    wanted_rate_hz <= rate;
    do @(posedge clk); while (busy);
  endtask

  // Stop sending and wait until every pending result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pick_queue.size() != 0) @(posedge clk);
  endtask

  // Write the core clock register while nothing is in flight.
  task automatic write_core_clock(input word_t value);
    drain_results();
    core_clock_hz_we <= 1'b1;
    core_clock_hz <= value;
    cur_core_clock = value;
    @(posedge clk);
    core_clock_hz_we <= 1'b0;
  endtask

  // Predict on each accepted word; check each result strobe.
  always @(posedge clk) begin
    prescale_pick_t oldest;
    if (rst) begin
      model_core_clock = CORE_CLOCK_RESET;
    end else begin
      if (done) begin
        if (pick_queue.size() == 0) begin
          $error("result with no request pending: primary_code=%0d secondary_code=%0d",
                 primary_code, secondary_code);
          fail_count++;
        end else begin
          oldest = pick_queue.pop_front();
          if (primary_code !== oldest.primary) begin
            $error("primary_code: expected %0d, actual %0d (wanted %0d, clock %0d)",
                   oldest.primary, primary_code, oldest.wanted, oldest.clock_hz);
            fail_count++;
          end
          if (secondary_code !== oldest.secondary) begin
            $error("secondary_code: expected %0d, actual %0d (wanted %0d, clock %0d)",
                   oldest.secondary, secondary_code, oldest.wanted, oldest.clock_hz);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        pick_queue.push_back(best_prescaler(model_core_clock, wanted_rate_hz));
        accepted_count++;
      end
      if (core_clock_hz_we) begin
        model_core_clock = core_clock_hz;
        setting_count++;
      end
    end
  end

  // Directed words at the reset clock of 16 MHz, ties included.
  task automatic test_reset_clock();
    send_rate('0);
    send_rate(FIELD_MAX);
    send_rate(RATE_TOP);
    send_rate(28'd16000000);
    send_rate(28'd8000000);
    send_rate(28'd250000);
    send_rate(28'd31250);
    // Halfway between the two slowest rates: the first pair wins the tie.
    send_rate(28'd33482);
    // Two pairs give this rate exactly: the first one found wins.
    send_rate(28'd125000);
    send_rate(28'd1);
  endtask

  // Core clock at zero, one, the stated top and the full field.
  task automatic test_clock_extremes();
    write_core_clock('0);
    send_rate('0);
    send_rate(FIELD_MAX);
    write_core_clock(FIELD_MAX);
    send_rate(FIELD_MAX);
    send_rate('0);
    send_rate(28'd1);
    write_core_clock(28'd1);
    send_rate('0);
    send_rate(28'd1);
    write_core_clock(RATE_TOP);
    send_rate(RATE_TOP);
    send_rate(28'd100000000);
  endtask

  // Random words over a series of random core clock settings.
  task automatic test_random_settings();
    word_t clock_choice;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 4))
        0: clock_choice = word_t'($urandom_range(1, RATE_TOP));
        1: clock_choice = word_t'($urandom_range(0, 32'hFFFF_FFFF));
        2: clock_choice = word_t'($urandom_range(1, 5000));
        3: clock_choice = RATE_TOP;
        default: clock_choice = CORE_CLOCK_RESET;
      endcase
      write_core_clock(clock_choice);
      for (int i = 0; i < 60; i++) begin
        // Once per phase the sender holds off until all results are back.
        if (i == 30) drain_results();
        send_rate(rand_wanted());
      end
    end
  endtask

  // Back-to-back words with no gaps at a random clock.
  task automatic test_burst();
    write_core_clock(word_t'($urandom_range(1, RATE_TOP)));
    no_gaps = 1'b1;
    for (int i = 0; i < 120; i++) send_rate(rand_wanted());
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_clock();
    test_clock_extremes();
    test_random_settings();
    test_burst();
    drain_results();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    $display("Checked %0d request words over %0d core clock writes,", accepted_count,
             setting_count);
    $display("covering ties, zero and full-field values, and gapped and burst traffic.");
    if (fail_count == 0 && pick_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
